>>> hw/rtl/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Shared types and constants of the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  localparam int MAX_LENGTH = 256;
  localparam int BUF_DEPTH  = 256;
  localparam int BUF_AW     = $clog2(BUF_DEPTH);

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  // request kinds (in_tuser)
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_EVENT = 2'd2;

  // bus controller status codes
  localparam logic [7:0] SC_BUS_ERROR    = 8'h00;
  localparam logic [7:0] SC_START        = 8'h08;
  localparam logic [7:0] SC_RSTART       = 8'h10;
  localparam logic [7:0] SC_ADDR_W_ACK   = 8'h18;
  localparam logic [7:0] SC_ADDR_W_NACK  = 8'h20;
  localparam logic [7:0] SC_DATA_TX_ACK  = 8'h28;
  localparam logic [7:0] SC_DATA_TX_NACK = 8'h30;
  localparam logic [7:0] SC_ARB_LOST     = 8'h38;
  localparam logic [7:0] SC_ADDR_R_ACK   = 8'h40;
  localparam logic [7:0] SC_ADDR_R_NACK  = 8'h48;
  localparam logic [7:0] SC_DATA_RX_ACK  = 8'h50;
  localparam logic [7:0] SC_DATA_RX_NACK = 8'h58;

  // acknowledge actions
  localparam logic [1:0] ACK_KEEP = 2'd0;
  localparam logic [1:0] ACK_SET  = 2'd1;
  localparam logic [1:0] ACK_CLR  = 2'd2;

  // completion status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NODEV  = 2'd1;
  localparam logic [1:0] ST_BADARG = 2'd2;
  localparam logic [1:0] ST_UNSUP  = 2'd3;

  // result, packed so that ctl_start is bit 0
  typedef struct packed {
    logic [1:0] status;
    logic       done_res;
    logic [7:0] rx_index;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic [7:0] tx_data;
    logic       tx_valid;
    logic       clear_start;
    logic [1:0] ack_action;
    logic       ctl_stop;
    logic       ctl_start;
  } res_t;

endpackage

>>> hw/rtl/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Sequences one I2C master read or write transfer from bus status codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects the request (load transmit byte, start
//   transfer, bus status event); in_tdata carries the request fields.
//   Output stream: exactly one result transaction per input transaction,
//   in order, carrying the controller actions, transmit/receive bytes and
//   completion status.
//   Throughput: one transaction per cycle while the output is not stalled;
//   the registered read of the transmit buffer RAM sets the first stage,
//   the output register the second.
//   The transmit buffer is a 256 x 8 synchronous RAM written by load
//   requests and read at the current byte position on data-send events.
//   Reset: transfer state idle, pipeline empty; the buffer RAM is not
//   cleared and needs no clearing pass.
//   When out_tready is low, one more transaction is taken into the first
//   stage, then in_tready drops until the output register drains.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] buffer_index, [15:8] tx_byte, [22:16] slave_addr, [23] read_not_write,
  // [32:24] transfer_length, [33] ten_bit_request, [41:34] status_code,
  // [49:42] rx_byte, [55:50] zero
  input  logic [i2cmts_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] req_type
  input  logic [i2cmts_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] ctl_start, [1] ctl_stop, [3:2] ack_action, [4] clear_start,
  // [5] tx_valid, [13:6] tx_data, [14] rx_valid, [22:15] rx_data,
  // [30:23] rx_index, [31] done_res, [33:32] status, [39:34] zero
  output logic [i2cmts_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import i2cmts_pkg::*;

  // input fields
  logic [7:0] f_buffer_index, f_tx_byte, f_status_code, f_rx_byte;
  logic [6:0] f_slave_addr;
  logic       f_rnw, f_ten;
  logic [8:0] f_len;

  assign f_buffer_index = in_tdata[7:0];
  assign f_tx_byte      = in_tdata[15:8];
  assign f_slave_addr   = in_tdata[22:16];
  assign f_rnw          = in_tdata[23];
  assign f_len          = in_tdata[32:24];
  assign f_ten          = in_tdata[33];
  assign f_status_code  = in_tdata[41:34];
  assign f_rx_byte      = in_tdata[49:42];

  // transfer state
  logic       busy_r, busy_nxt;
  logic [7:0] addr_byte_r, addr_byte_nxt;
  logic [8:0] pos_r, pos_nxt;
  logic [8:0] len_r, len_nxt;

  // pipeline
  logic       s1_valid_r, s1_valid_nxt;
  res_t       s1_res_r, s1_res_nxt;
  logic       s1_use_mem_r, s1_use_mem_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r, out_res_nxt;

  // transmit buffer
  logic [7:0]        buf_mem [BUF_DEPTH];
  logic [7:0]        buf_rdata_r;
  logic              buf_we, buf_re;
  logic [BUF_AW-1:0] buf_raddr;

  logic adv, acc;
  logic [8:0] pos_rx;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    busy_nxt       = busy_r;
    addr_byte_nxt  = addr_byte_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    s1_res_nxt     = '0;
    s1_use_mem_nxt = 1'b0;
    buf_we         = 1'b0;
    buf_re         = 1'b0;
    buf_raddr      = pos_r[BUF_AW-1:0];
    pos_rx         = pos_r;
    if (acc) begin
      case (in_tuser)
        REQ_LOAD: begin
          buf_we = 1'b1;
        end
        REQ_START: begin
          if (!busy_r) begin
            if (f_len == 9'd0 || 32'(f_len) > MAX_LENGTH) begin
              s1_res_nxt.done_res = 1'b1;
              s1_res_nxt.status   = ST_BADARG;
            end else if (f_ten) begin
              s1_res_nxt.done_res = 1'b1;
              s1_res_nxt.status   = ST_UNSUP;
            end else begin
              addr_byte_nxt        = {f_slave_addr, f_rnw};
              pos_nxt              = 9'd0;
              len_nxt              = f_len;
              busy_nxt             = 1'b1;
              s1_res_nxt.ctl_start = 1'b1;
            end
          end
        end
        REQ_EVENT: begin
          if (busy_r) begin
            case (f_status_code)
              SC_START, SC_RSTART: begin
                pos_nxt                = 9'd0;
                s1_res_nxt.tx_valid    = 1'b1;
                s1_res_nxt.tx_data     = addr_byte_r;
                s1_res_nxt.ack_action  = ACK_SET;
                s1_res_nxt.clear_start = 1'b1;
              end
              SC_ADDR_W_NACK, SC_ADDR_R_NACK: begin
                s1_res_nxt.ctl_stop   = 1'b1;
                s1_res_nxt.ack_action = ACK_SET;
                s1_res_nxt.done_res   = 1'b1;
                s1_res_nxt.status     = ST_NODEV;
                busy_nxt              = 1'b0;
              end
              SC_ADDR_W_ACK, SC_DATA_TX_ACK: begin
                s1_res_nxt.ack_action = ACK_SET;
                if (pos_r >= len_r) begin
                  s1_res_nxt.ctl_stop = 1'b1;
                  s1_res_nxt.done_res = 1'b1;
                  s1_res_nxt.status   = ST_OK;
                  busy_nxt            = 1'b0;
                end else begin
                  // data byte is read from the buffer RAM into a register and merged on the way to the output register
                  s1_res_nxt.tx_valid = 1'b1;
                  s1_use_mem_nxt      = 1'b1;
                  buf_re              = 1'b1;
                  pos_nxt             = pos_r + 9'd1;
                end
              end
              SC_DATA_TX_NACK: begin
                s1_res_nxt.ctl_stop   = 1'b1;
                s1_res_nxt.ack_action = ACK_SET;
                s1_res_nxt.done_res   = 1'b1;
                s1_res_nxt.status     = ST_OK;
                busy_nxt              = 1'b0;
              end
              SC_ARB_LOST: begin
                s1_res_nxt.ctl_start  = 1'b1;
                s1_res_nxt.ack_action = ACK_SET;
              end
              SC_ADDR_R_ACK: begin
                s1_res_nxt.ack_action = (len_r == 9'd1) ? ACK_CLR : ACK_SET;
              end
              SC_DATA_RX_ACK: begin
                s1_res_nxt.rx_valid = 1'b1;
                s1_res_nxt.rx_data  = f_rx_byte;
                s1_res_nxt.rx_index = pos_r[7:0];
                if (pos_r < len_r) pos_rx = pos_r + 9'd1;
                pos_nxt = pos_rx;
                // clear ack ahead of the last byte
                s1_res_nxt.ack_action =
                  ((10'(pos_rx) + 10'd1) == 10'(len_r)) ? ACK_CLR : ACK_SET;
              end
              SC_DATA_RX_NACK: begin
                s1_res_nxt.rx_valid   = 1'b1;
                s1_res_nxt.rx_data    = f_rx_byte;
                s1_res_nxt.rx_index   = pos_r[7:0];
                s1_res_nxt.ctl_stop   = 1'b1;
                s1_res_nxt.ack_action = ACK_SET;
                s1_res_nxt.done_res   = 1'b1;
                s1_res_nxt.status     = ST_OK;
                busy_nxt              = 1'b0;
              end
              SC_BUS_ERROR: begin
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc)      s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (adv)             out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // merge the buffer read data into the staged result
  always_comb begin
    out_res_nxt = s1_res_r;
    if (s1_use_mem_r) out_res_nxt.tx_data = buf_rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      addr_byte_r <= '0;
      pos_r       <= '0;
      len_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      addr_byte_r <= addr_byte_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r     <= s1_res_nxt;
      s1_use_mem_r <= s1_use_mem_nxt;
    end
    if (adv) out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[f_buffer_index[BUF_AW-1:0]] <= f_tx_byte;
    if (buf_re) buf_rdata_r <= buf_mem[buf_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), out_res_r};

  // assertions
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= len_r)
    else $error("byte position beyond transfer length");

  a_tx_rx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.tx_valid && out_res_r.rx_valid))
    else $error("transmit and receive in one result");

  a_nodev_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.done_res && out_res_r.status == ST_NODEV)
      |-> out_res_r.ctl_stop)
    else $error("no-device completion without stop");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> s1_valid_r)
    else $error("first stage lost while output stalled");

endmodule

>>> dv/i2cmts_sequence_checker.sv
// ----------------------------------------------------------------------------
// i2cmts_sequence_checker
// Watches both streams of the I2C master transfer sequencer, predicts the
// controller actions for every accepted request and compares them, field by
// field and in order, with the result transactions that the block returns.
// ----------------------------------------------------------------------------
module i2cmts_sequence_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [i2cmts_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [i2cmts_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [i2cmts_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                                mismatches,
  output int                                pending
);
  import i2cmts_pkg::*;

  localparam int RES_W = $bits(res_t);

  // transfer state as the sequencer should hold it
  logic       xfer_busy;
  logic [7:0] addr_byte;
  logic [8:0] byte_pos;
  logic [8:0] xfer_len;
  logic [7:0] tx_mem [BUF_DEPTH];

  res_t expected_actions [$];
  int   fails = 0;

  function automatic res_t predict_actions(input logic [IN_USER_W-1:0] kind,
                                           input logic [IN_DATA_W-1:0] d);
    res_t       r;
    logic       end_xfer;
    logic [1:0] end_code;
    logic [8:0] len;
    logic [7:0] sc;
    logic [7:0] rx;
    r        = '0;
    end_xfer = 1'b0;
    end_code = ST_OK;
    len      = d[32:24];
    sc       = d[41:34];
    rx       = d[49:42];
    case (kind)
      REQ_LOAD: tx_mem[d[7:0]] = d[15:8];
      REQ_START: begin
        if (!xfer_busy) begin
          if (len == 0 || len > MAX_LENGTH) begin
            r.done_res = 1'b1;
            r.status   = ST_BADARG;
          end else if (d[33]) begin
            r.done_res = 1'b1;
            r.status   = ST_UNSUP;
          end else begin
            addr_byte   = {d[22:16], d[23]};
            byte_pos    = '0;
            xfer_len    = len;
            xfer_busy   = 1'b1;
            r.ctl_start = 1'b1;
          end
        end
      end
      REQ_EVENT: begin
        if (xfer_busy) begin
          case (sc)
            SC_START, SC_RSTART: begin
              byte_pos      = '0;
              r.tx_valid    = 1'b1;
              r.tx_data     = addr_byte;
              r.ack_action  = ACK_SET;
              r.clear_start = 1'b1;
            end
            SC_ADDR_W_NACK, SC_ADDR_R_NACK: begin
              end_xfer = 1'b1;
              end_code = ST_NODEV;
            end
            SC_ADDR_W_ACK, SC_DATA_TX_ACK: begin
              // a send at the saturated position closes the transfer
              if (byte_pos >= xfer_len) begin
                end_xfer = 1'b1;
              end else begin
                r.tx_valid   = 1'b1;
                r.tx_data    = tx_mem[byte_pos[7:0]];
                byte_pos     = byte_pos + 9'd1;
                r.ack_action = ACK_SET;
              end
            end
            SC_DATA_TX_NACK: end_xfer = 1'b1;
            SC_ARB_LOST: begin
              r.ctl_start  = 1'b1;
              r.ack_action = ACK_SET;
            end
            SC_ADDR_R_ACK: r.ack_action = (xfer_len == 9'd1) ? ACK_CLR : ACK_SET;
            SC_DATA_RX_ACK: begin
              r.rx_valid = 1'b1;
              r.rx_data  = rx;
              r.rx_index = byte_pos[7:0];
              if (byte_pos < xfer_len) byte_pos = byte_pos + 9'd1;
              r.ack_action = (byte_pos + 10'd1 == {1'b0, xfer_len}) ? ACK_CLR : ACK_SET;
            end
            SC_DATA_RX_NACK: begin
              r.rx_valid = 1'b1;
              r.rx_data  = rx;
              r.rx_index = byte_pos[7:0];
              end_xfer   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (end_xfer) begin
      r.ctl_stop   = 1'b1;
      r.ack_action = ACK_SET;
      r.done_res   = 1'b1;
      r.status     = end_code;
      xfer_busy    = 1'b0;
    end
    return r;
  endfunction

  function automatic string action_text(input res_t r);
    return $sformatf({"start=%0d stop=%0d ack=%0d clrsta=%0d tx=%0d/%h ",
                      "rx=%0d/%h@%0d done=%0d st=%0d"},
                     r.ctl_start, r.ctl_stop, r.ack_action, r.clear_start, r.tx_valid,
                     r.tx_data, r.rx_valid, r.rx_data, r.rx_index, r.done_res, r.status);
  endfunction

  always @(posedge clk) begin
    res_t  exp_r;
    res_t  act_r;
    string diff;
    if (!rst_n) begin
      xfer_busy = 1'b0;
      addr_byte = '0;
      byte_pos  = '0;
      xfer_len  = '0;
      expected_actions.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_actions.push_back(predict_actions(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        act_r = res_t'(out_tdata[RES_W-1:0]);
        if (expected_actions.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected result transaction: %s", $realtime, action_text(act_r));
        end else begin
          exp_r = expected_actions.pop_front();
          diff  = "";
          if (act_r.ctl_start !== exp_r.ctl_start)     diff = {diff, " ctl_start"};
          if (act_r.ctl_stop !== exp_r.ctl_stop)       diff = {diff, " ctl_stop"};
          if (act_r.ack_action !== exp_r.ack_action)   diff = {diff, " ack_action"};
          if (act_r.clear_start !== exp_r.clear_start) diff = {diff, " clear_start"};
          if (act_r.tx_valid !== exp_r.tx_valid)       diff = {diff, " tx_valid"};
          if (act_r.tx_data !== exp_r.tx_data)         diff = {diff, " tx_data"};
          if (act_r.rx_valid !== exp_r.rx_valid)       diff = {diff, " rx_valid"};
          if (act_r.rx_data !== exp_r.rx_data)         diff = {diff, " rx_data"};
          if (act_r.rx_index !== exp_r.rx_index)       diff = {diff, " rx_index"};
          if (act_r.done_res !== exp_r.done_res)       diff = {diff, " done_res"};
          if (act_r.status !== exp_r.status)           diff = {diff, " status"};
          if (out_tdata[OUT_DATA_W-1:RES_W] !== '0)    diff = {diff, " padding"};
          if (diff != "") begin
            fails++;
            if (fails <= 10) begin
              $display("[%0t] result mismatch in:%s", $realtime, diff);
              $display("  expected %s", action_text(exp_r));
              $display("  actual   %s", action_text(act_r));
            end
          end
        end
      end
    end
    pending    <= expected_actions.size();
    mismatches <= fails;
  end

endmodule

>>> dv/tb_i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer
// Drives load, start and bus status requests into the transfer sequencer:
// a directed pass over every status code but SC_ADDR_R_NACK and corner cases, then random
// well-formed read and write transfers mixed with noise and cut-off
// sequences, under random idling on both streams. Checking is done by
// i2cmts_sequence_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer;
  import i2cmts_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam logic [7:0] SC_UNDEFINED = 8'hF8;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int   mismatches;
  int   pending;
  int   sent         = 0;
  int   bus_budget   = 1000;
  int   stall_cycles = 0;
  bit   written [BUF_DEPTH];
  logic calm;

  // one stretch of the run with no idling on either side
  assign calm = (sent >= 150) && (sent < 260);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  i2c_master_transfer_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  i2cmts_sequence_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else if (rst_n) stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // unused fields carry random bits so that the block must ignore them
  function automatic logic [IN_DATA_W-1:0] noise_bits();
    return {6'd0, 50'({$urandom, $urandom})};
  endfunction

  task automatic send_item(input logic [IN_USER_W-1:0] kind,
                           input logic [IN_DATA_W-1:0] data);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic load_byte(input logic [7:0] idx, input logic [7:0] val);
    logic [IN_DATA_W-1:0] d;
    d       = noise_bits();
    d[7:0]  = idx;
    d[15:8] = val;
    send_item(REQ_LOAD, d);
    written[idx] = 1'b1;
  endtask

  // unwritten buffer entries below the length are loaded first: a transfer never
  // reads a transmit entry that was not written
  task automatic start_transfer(input logic [6:0] addr, input logic rnw,
                                input logic [8:0] len, input logic ten);
    logic [IN_DATA_W-1:0] d;
    if (!ten)
      for (int i = 0; i < len && i < BUF_DEPTH; i++)
        if (!written[i]) load_byte(8'(i), 8'($urandom_range(255)));
    d        = noise_bits();
    d[22:16] = addr;
    d[23]    = rnw;
    d[32:24] = len;
    d[33]    = ten;
    send_item(REQ_START, d);
  endtask

  // bus_budget cuts a sequence short when it runs out
  task automatic bus_event(input logic [7:0] sc, input logic [7:0] rx);
    logic [IN_DATA_W-1:0] d;
    if (bus_budget > 0) begin
      bus_budget--;
      d        = noise_bits();
      d[41:34] = sc;
      d[49:42] = rx;
      send_item(REQ_EVENT, d);
    end
  endtask

  initial begin
    logic [6:0] addr;
    logic       rnw;
    logic [8:0] len;
    int         nack_at;
    int         n;
    int         directed_count;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle event, unused request, rejected starts
    bus_event(SC_START, 8'h00);
    send_item(REQ_UNUSED, noise_bits());
    start_transfer(7'h12, 1'b0, 9'd0, 1'b0);
    start_transfer(7'h12, 1'b1, 9'd256, 1'b1);
    load_byte(8'd0, 8'hFF);
    load_byte(8'd255, 8'h00);

    // write of two bytes with arbitration loss, a start while busy,
    // and a closing send at the saturated position
    start_transfer(7'h7F, 1'b0, 9'd2, 1'b0);
    start_transfer(7'h00, 1'b1, 9'd5, 1'b0);
    bus_event(SC_START, 8'h3C);
    bus_event(SC_ARB_LOST, 8'hC3);
    bus_event(SC_RSTART, 8'h11);
    bus_event(SC_ADDR_W_ACK, 8'h22);
    bus_event(SC_DATA_TX_ACK, 8'h44);
    bus_event(SC_DATA_TX_ACK, 8'h88);

    // one-byte read
    start_transfer(7'h00, 1'b1, 9'd1, 1'b0);
    bus_event(SC_START, 8'h00);
    bus_event(SC_ADDR_R_ACK, 8'h00);
    bus_event(SC_DATA_RX_NACK, 8'hFF);

    // two-byte read with bus error, unknown code and a position overrun
    start_transfer(7'h55, 1'b1, 9'd2, 1'b0);
    bus_event(SC_START, 8'h00);
    bus_event(SC_BUS_ERROR, 8'h00);
    bus_event(SC_UNDEFINED, 8'hFF);
    bus_event(SC_ADDR_R_ACK, 8'h00);
    bus_event(SC_DATA_RX_ACK, 8'h00);
    bus_event(SC_DATA_RX_ACK, 8'hAA);
    bus_event(SC_DATA_RX_ACK, 8'h5A);
    bus_event(SC_ADDR_W_NACK, 8'h00);

    // write ended by a data NACK
    start_transfer(7'h2A, 1'b0, 9'd3, 1'b0);
    bus_event(SC_START, 8'h00);
    bus_event(SC_ADDR_W_ACK, 8'h00);
    bus_event(SC_DATA_TX_NACK, 8'h00);

    directed_count = sent;
    while (sent < directed_count + RANDOM_ITEMS) begin
      if ($urandom_range(99) < 75) begin
        // well-formed transfer, now and then cut off part way
        addr       = 7'($urandom_range(127));
        rnw        = 1'($urandom_range(1));
        len        = ($urandom_range(39) == 0) ? 9'($urandom_range(256, 9))
                                               : 9'($urandom_range(8, 1));
        bus_budget = ($urandom_range(9) == 0) ? $urandom_range(4) : 1000;
        start_transfer(addr, rnw, len, 1'b0);
        bus_event(SC_START, 8'($urandom_range(255)));
        if ($urandom_range(9) == 0) begin
          bus_event(SC_ARB_LOST, 8'($urandom_range(255)));
          bus_event(SC_RSTART, 8'($urandom_range(255)));
        end
        if (!rnw) begin
          if ($urandom_range(9) == 0) begin
            bus_event(SC_ADDR_W_NACK, 8'($urandom_range(255)));
          end else begin
            nack_at = ($urandom_range(7) == 0) ? $urandom_range(len, 1) : 0;
            n       = (nack_at != 0) ? nack_at : len;
            bus_event(SC_ADDR_W_ACK, 8'($urandom_range(255)));
            for (int i = 1; i <= n; i++)
              bus_event((i == nack_at) ? SC_DATA_TX_NACK : SC_DATA_TX_ACK,
                        8'($urandom_range(255)));
          end
        end else begin
          if ($urandom_range(9) == 0) begin
            bus_event(SC_ADDR_R_NACK, 8'($urandom_range(255)));
          end else begin
            bus_event(SC_ADDR_R_ACK, 8'($urandom_range(255)));
            for (int i = 1; i < len; i++)
              bus_event(SC_DATA_RX_ACK, 8'($urandom_range(255)));
            bus_event(SC_DATA_RX_NACK, 8'($urandom_range(255)));
          end
        end
      end else begin
        bus_budget = 1000;
        case ($urandom_range(3))
          0: load_byte(8'($urandom_range(255)), 8'($urandom_range(255)));
          1: start_transfer(7'($urandom_range(127)), 1'($urandom_range(1)),
                            9'($urandom_range(256)), $urandom_range(3) == 0);
          default: bus_event(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                      : 8'(8 * $urandom_range(11)),
                             8'($urandom_range(255)));
        endcase
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
